FILE: src/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

   localparam int ADDR_W = 25;
   localparam int END_W = 26;
   localparam int HDR_W = 8;
   localparam int STATUS_W = 3;
   localparam int CSR_AW = 3;

   localparam logic [HDR_W-1:0] HEADER_RESET = 8'd24;
   localparam logic [END_W-1:0] ARENA_RESET = 26'd26214400;
   localparam logic [END_W-1:0] ARENA_CAP = 26'd33554432;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE = 1'b1;

   localparam logic REG_HEADER = 1'b0;
   localparam logic REG_ARENA = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ARENA_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FREE_FAILED = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic              free;
   } tbl_entry_type;

   typedef struct packed {
      logic [HDR_W-1:0] header;
      logic [END_W-1:0] limit;
   } cfg_type;

endpackage
`default_nettype wire

FILE: src/ffba_ifs.sv
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ffba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [ffba_pkg::ADDR_W-1:0] req_size;
   logic [ffba_pkg::ADDR_W-1:0] payload_addr;

   modport source(output valid, output mode, output req_size, output payload_addr,
                  input ready);
   modport sink(input valid, input mode, input req_size, input payload_addr,
                output ready);
endinterface

interface ffba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffba_pkg::STATUS_W-1:0] status;
   logic [ffba_pkg::ADDR_W-1:0]   result_addr;

   modport source(output valid, output status, output result_addr, input ready);
   modport sink(input valid, input status, input result_addr, output ready);
endinterface
`default_nettype wire

FILE: src/first_fit_block_allocator.sv
// Top level of the first-fit block allocator.
// Each request word (allocate or free) is answered with exactly one response
// word. The block takes one request at a time: a lookup walks the block table
// through its single read port at one entry per cycle, over the N blocks in
// the table (at most MAX_BLOCKS), and the answer may wait for the response
// register to drain; a size-zero allocate skips the walk. An allocate that
// finds no free block large enough appends a new block when the table and
// the arena have room. The table needs no clearing after reset: only entries
// below the block count are ever read.
// The configuration registers (header bytes at 0x0, arena bytes at 0x4)
// should be written only while no request is in flight.
`default_nettype none
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ffba_req_if.sink                         req_ch,
   ffba_rsp_if.source                       rsp_ch,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [ffba_pkg::CSR_AW-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   ffba_pkg::cfg_type cfg;

   ffba_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ffba_engine #(.MAX_BLOCKS(MAX_BLOCKS)) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire

FILE: src/ffba_csr.sv
// APB-style configuration registers: header size and arena size.
`default_nettype none
module ffba_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [ffba_pkg::CSR_AW-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output ffba_pkg::cfg_type                cfg
);

   logic [ffba_pkg::HDR_W-1:0] header_ff, header_in;
   logic [ffba_pkg::END_W-1:0] arena_ff, arena_in;
   logic                       reg_sel;
   logic                       wr_en;

   assign reg_sel = paddr[ffba_pkg::CSR_AW-1];
   assign wr_en = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      header_in = header_ff;
      arena_in = arena_ff;
      if (wr_en) begin
         if (reg_sel == ffba_pkg::REG_HEADER) begin
            header_in = pwdata[ffba_pkg::HDR_W-1:0];
         end else begin
            arena_in = pwdata[ffba_pkg::END_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= ffba_pkg::HEADER_RESET;
         arena_ff <= ffba_pkg::ARENA_RESET;
      end else begin
         header_ff <= header_in;
         arena_ff <= arena_in;
      end
   end

   always_comb begin
      if (reg_sel == ffba_pkg::REG_HEADER) begin
         prdata = {{(32 - ffba_pkg::HDR_W){1'b0}}, header_ff};
      end else begin
         prdata = {{(32 - ffba_pkg::END_W){1'b0}}, arena_ff};
      end
   end

   // The arena never grows past the 25-bit offset space.
   assign cfg.header = header_ff;
   assign cfg.limit = (arena_ff > ffba_pkg::ARENA_CAP) ? ffba_pkg::ARENA_CAP : arena_ff;

endmodule
`default_nettype wire

FILE: src/ffba_table.sv
// Block table memory: one write port and one registered read port.
`default_nettype none
module ffba_table #(
   parameter int DEPTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire ffba_pkg::tbl_entry_type       wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output ffba_pkg::tbl_entry_type            rd_data
);

   ffba_pkg::tbl_entry_type mem [DEPTH];
   ffba_pkg::tbl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/ffba_match.sv
// Shared compare unit: tests one table entry against the current request.
`default_nettype none
module ffba_match (
   input  wire ffba_pkg::tbl_entry_type       entry,
   input  wire logic                          mode,
   input  wire logic [ffba_pkg::ADDR_W-1:0]   want,
   input  wire logic [ffba_pkg::ADDR_W-1:0]   addr,
   input  wire logic [ffba_pkg::HDR_W-1:0]    header,
   output logic                               hit,
   output logic [ffba_pkg::ADDR_W-1:0]        payload_off
);

   logic [ffba_pkg::END_W-1:0] sum;

   // The free lookup compares the untruncated sum, so a start near the top of
   // the offset space never aliases onto a low payload address.
   assign sum = {1'b0, entry.start} + ffba_pkg::END_W'(header);
   assign payload_off = sum[ffba_pkg::ADDR_W-1:0];

   always_comb begin
      if (mode == ffba_pkg::MODE_FREE) begin
         hit = (sum == {1'b0, addr});
      end else begin
         hit = entry.free && (entry.size >= want);
      end
   end

endmodule
`default_nettype wire

FILE: src/ffba_engine.sv
// Scan sequencer: walks the block table one entry per cycle and answers.
`default_nettype none
module ffba_engine #(
   parameter int MAX_BLOCKS = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ffba_pkg::cfg_type     cfg,
   ffba_req_if.sink                   req_ch,
   ffba_rsp_if.source                 rsp_ch
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = ffba_pkg::ADDR_W;
   localparam int EW = ffba_pkg::END_W;
   localparam int SW = ffba_pkg::STATUS_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [EW-1:0] end_ff, end_in;
   logic          mode_ff, mode_in;
   logic [AW-1:0] want_ff, want_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [SW-1:0] res_status_ff, res_status_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;

   logic                    tbl_we;
   logic [IW-1:0]           tbl_waddr;
   ffba_pkg::tbl_entry_type tbl_wdata;
   logic                    tbl_re;
   ffba_pkg::tbl_entry_type rd_data;
   logic                    hit;
   logic [AW-1:0]           payload_off;
   logic [EW:0]             new_end;
   logic [AW-1:0]           tail_off;

   ffba_table #(.DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   ffba_match u_match (
      .entry       (rd_data),
      .mode        (mode_ff),
      .want        (want_ff),
      .addr        (addr_ff),
      .header      (cfg.header),
      .hit         (hit),
      .payload_off (payload_off)
   );

   assign new_end = {1'b0, end_ff} + (EW + 1)'(cfg.header) + (EW + 1)'(want_ff);
   assign tail_off = end_ff[AW-1:0] + AW'(cfg.header);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      pend_idx_in = pend_idx_ff;
      count_in = count_ff;
      end_in = end_ff;
      mode_in = mode_ff;
      want_in = want_ff;
      addr_in = addr_ff;
      res_status_in = res_status_ff;
      res_addr_in = res_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      tbl_we = 1'b0;
      tbl_waddr = pend_idx_ff;
      tbl_wdata = rd_data;
      tbl_re = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               want_in = req_ch.req_size;
               addr_in = req_ch.payload_addr;
               idx_in = '0;
               pend_in = 1'b0;
               res_addr_in = '0;
               if (req_ch.mode == ffba_pkg::MODE_ALLOC && req_ch.req_size == '0) begin
                  res_status_in = ffba_pkg::STATUS_BAD_SIZE;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Each read is issued in the cycle before its word is compared; pend_ff marks
            // a word that has just come back from the table and is being compared now.
            pend_in = 1'b0;
            if (pend_ff && hit) begin
               state_in = ST_FIN;
               if (mode_ff == ffba_pkg::MODE_ALLOC) begin
                  tbl_we = 1'b1;
                  tbl_wdata.free = 1'b0;
                  res_status_in = ffba_pkg::STATUS_OK;
                  res_addr_in = payload_off;
               end else if (!rd_data.free) begin
                  tbl_we = 1'b1;
                  tbl_wdata.free = 1'b1;
                  res_status_in = ffba_pkg::STATUS_OK;
               end else begin
                  res_status_in = ffba_pkg::STATUS_FREE_FAILED;
               end
            end else if (idx_ff != count_ff) begin
               tbl_re = 1'b1;
               idx_in = idx_ff + CW'(1);
               pend_in = 1'b1;
               pend_idx_in = idx_ff[IW-1:0];
            end else if (!pend_ff) begin
               state_in = ST_FIN;
               if (mode_ff == ffba_pkg::MODE_FREE) begin
                  res_status_in = ffba_pkg::STATUS_FREE_FAILED;
               end else if (count_ff == CW'(MAX_BLOCKS)) begin
                  res_status_in = ffba_pkg::STATUS_TABLE_FULL;
               end else if (new_end > {1'b0, cfg.limit}) begin
                  res_status_in = ffba_pkg::STATUS_ARENA_FULL;
               end else begin
                  tbl_we = 1'b1;
                  tbl_waddr = count_ff[IW-1:0];
                  tbl_wdata.start = end_ff[AW-1:0];
                  tbl_wdata.size = want_ff;
                  tbl_wdata.free = 1'b0;
                  count_in = count_ff + CW'(1);
                  end_in = new_end[EW-1:0];
                  res_status_in = ffba_pkg::STATUS_OK;
                  res_addr_in = tail_off;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in = res_addr_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         pend_ff <= 1'b0;
         count_ff <= '0;
         end_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         end_ff <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      mode_ff <= mode_in;
      want_ff <= want_in;
      addr_ff <= addr_in;
      res_status_ff <= res_status_in;
      res_addr_ff <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("block count exceeds table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index ran past the block count");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start a lookup");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (state_ff == ST_SCAN))
      else $error("table written outside a scan");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ffba_pkg::STATUS_OK) |-> (rsp_addr_ff == '0))
      else $error("failed response carries a nonzero address");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the first-fit block allocator.
module tb;

   localparam int MAX_BLOCKS = 256;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int AW = ffba_pkg::ADDR_W;
   localparam int EW = ffba_pkg::END_W;
   localparam int HW = ffba_pkg::HDR_W;
   localparam int SW = ffba_pkg::STATUS_W;
   localparam int CAW = ffba_pkg::CSR_AW;
   localparam logic [AW-1:0] ADDR_MAX = '1;
   localparam logic [CAW-1:0] CSR_HEADER = CAW'(4 * int'(ffba_pkg::REG_HEADER));
   localparam logic [CAW-1:0] CSR_ARENA = CAW'(4 * int'(ffba_pkg::REG_ARENA));

   typedef struct packed {
      logic [SW-1:0] status;
      logic [AW-1:0] addr;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CAW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ffba_req_if req_ch();
   ffba_rsp_if rsp_ch();

   first_fit_block_allocator #(.MAX_BLOCKS(MAX_BLOCKS)) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // Shadow of the block table and the configuration.
   ffba_pkg::tbl_entry_type blk_table [MAX_BLOCKS];
   int               blk_count = 0;
   logic [EW-1:0]    arena_end = '0;
   logic [HW-1:0]    cfg_header = ffba_pkg::HEADER_RESET;
   logic [EW-1:0]    cfg_arena = ffba_pkg::ARENA_RESET;

   answer_type answers_due[$];
   int         mismatches = 0;
   int         cycle_count = 0;
   int         status_seen [5] = '{default: 0};
   int         n_allocs = 0;
   int         n_frees = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   logic       hold_rsp = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timed out with %0d answers outstanding", answers_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (answers_due.size() == 0) begin
            $error("response word with no request outstanding");
            mismatches++;
         end else begin
            due = answers_due.pop_front();
            status_seen[due.status]++;
            if (rsp_ch.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.result_addr !== due.addr) begin
               $error("result_addr: expected 0x%0h, got 0x%0h", due.addr,
                      rsp_ch.result_addr);
               mismatches++;
            end
         end
      end
   end

   function automatic logic [AW-1:0] payload_of(input int idx);
      return blk_table[idx].start + cfg_header;
   endfunction

   // Applies one request to the shadow table and returns the answer it earns.
   function automatic answer_type predict_answer(input logic mode,
                                                 input logic [AW-1:0] want,
                                                 input logic [AW-1:0] addr);
      answer_type     ans;
      logic [AW+1:0]  new_end;
      logic [EW-1:0]  ceiling;
      ans.status = ffba_pkg::STATUS_OK;
      ans.addr = '0;
      if (mode == ffba_pkg::MODE_FREE) begin
         // The lookup sum is not wrapped, so a payload past the top never matches.
         for (int i = 0; i < blk_count; i++) begin
            if (({1'b0, blk_table[i].start} + cfg_header) == {1'b0, addr}) begin
               if (blk_table[i].free) ans.status = ffba_pkg::STATUS_FREE_FAILED;
               else blk_table[i].free = 1'b1;
               return ans;
            end
         end
         ans.status = ffba_pkg::STATUS_FREE_FAILED;
         return ans;
      end
      if (want == '0) begin
         ans.status = ffba_pkg::STATUS_BAD_SIZE;
         return ans;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (blk_table[i].free && blk_table[i].size >= want) begin
            blk_table[i].free = 1'b0;
            ans.addr = blk_table[i].start + cfg_header;
            return ans;
         end
      end
      if (blk_count >= MAX_BLOCKS) begin
         ans.status = ffba_pkg::STATUS_TABLE_FULL;
         return ans;
      end
      new_end = arena_end + cfg_header + want;
      ceiling = (cfg_arena > ffba_pkg::ARENA_CAP) ? ffba_pkg::ARENA_CAP : cfg_arena;
      if (new_end > ceiling) begin
         ans.status = ffba_pkg::STATUS_ARENA_FULL;
         return ans;
      end
      blk_table[blk_count] = '{start: arena_end[AW-1:0], size: want, free: 1'b0};
      blk_count++;
      ans.addr = arena_end[AW-1:0] + cfg_header;
      arena_end = new_end[EW-1:0];
      return ans;
   endfunction

   task automatic send_word(input logic mode, input logic [AW-1:0] want,
                            input logic [AW-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.req_size <= want;
      req_ch.payload_addr <= addr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      answers_due.push_back(predict_answer(mode, want, addr));
      if (mode == ffba_pkg::MODE_ALLOC) n_allocs++;
      else n_frees++;
   endtask

   task automatic send_random_word(input int alloc_pct);
      int            pick;
      logic [AW-1:0] want;
      logic [AW-1:0] addr;
      pick = $urandom_range(99);
      want = AW'($urandom);
      addr = AW'($urandom);
      if ($urandom_range(99) < alloc_pct) begin
         if (pick < 3) want = '0;
         else if (pick < 8) want = AW'($urandom_range(ADDR_MAX, 1 << 24));
         else if (pick < 60) want = AW'($urandom_range(64, 1));
         else want = AW'($urandom_range(4096, 65));
         send_word(ffba_pkg::MODE_ALLOC, want, addr);
      end else begin
         if (blk_count > 0 && pick < 75) begin
            addr = payload_of($urandom_range(blk_count - 1));
         end else if (blk_count > 0 && pick < 85) begin
            addr = payload_of($urandom_range(blk_count - 1)) + 1'b1;
         end
         send_word(ffba_pkg::MODE_FREE, want, addr);
      end
   endtask

   task automatic wait_idle;
      req_ch.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CAW-1:0] where, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= where;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (where == CSR_HEADER) cfg_header = value[HW-1:0];
      else cfg_arena = value[EW-1:0];
      @(posedge clock);
   endtask

   task automatic test_alloc_and_free;
      send_word(ffba_pkg::MODE_ALLOC, '0, ADDR_MAX);
      send_word(ffba_pkg::MODE_ALLOC, AW'(1), '0);
      send_word(ffba_pkg::MODE_ALLOC, ADDR_MAX, '0);
      send_word(ffba_pkg::MODE_ALLOC, AW'(100), '0);
      send_word(ffba_pkg::MODE_ALLOC, AW'(40), '0);
      send_word(ffba_pkg::MODE_FREE, '0, payload_of(0));
      send_word(ffba_pkg::MODE_FREE, ADDR_MAX, payload_of(0));
      send_word(ffba_pkg::MODE_FREE, '0, '0);
      send_word(ffba_pkg::MODE_FREE, '0, ADDR_MAX);
      send_word(ffba_pkg::MODE_ALLOC, AW'(1), '0);
      send_word(ffba_pkg::MODE_FREE, '0, payload_of(1));
      // The reused block keeps its size of 100 after this grant.
      send_word(ffba_pkg::MODE_ALLOC, AW'(30), '0);
      send_word(ffba_pkg::MODE_FREE, '0, payload_of(1));
      send_word(ffba_pkg::MODE_ALLOC, AW'(100), '0);
      wait_idle();
   endtask

   task automatic test_config_edges;
      write_reg(CSR_HEADER, 0);
      send_word(ffba_pkg::MODE_FREE, '0, payload_of(2));
      send_word(ffba_pkg::MODE_ALLOC, AW'(40), '0);
      send_word(ffba_pkg::MODE_ALLOC, AW'(7), '0);
      wait_idle();
      write_reg(CSR_HEADER, 255);
      send_word(ffba_pkg::MODE_ALLOC, AW'(5), '0);
      send_word(ffba_pkg::MODE_FREE, '0, payload_of(0));
      wait_idle();
      write_reg(CSR_ARENA, 0);
      send_word(ffba_pkg::MODE_ALLOC, AW'(5000), '0);
      wait_idle();
      // Values above the cap saturate to it.
      write_reg(CSR_ARENA, 32'h3FF_FFFF);
      send_word(ffba_pkg::MODE_ALLOC, ADDR_MAX, '0);
      wait_idle();
      write_reg(CSR_ARENA, arena_end + cfg_header + 50);
      send_word(ffba_pkg::MODE_ALLOC, AW'(50), '0);
      send_word(ffba_pkg::MODE_ALLOC, AW'(51), '0);
      wait_idle();
      write_reg(CSR_HEADER, 32'(ffba_pkg::HEADER_RESET));
      write_reg(CSR_ARENA, 32'(ffba_pkg::ARENA_RESET));
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (12) send_random_word(70);
      wait_idle();
   endtask

   // A negative header or headroom picks a random setting.
   task automatic test_random_traffic(input int header, input int headroom,
                                      input int idle_pct, input int stall_pct);
      write_reg(CSR_HEADER, header < 0 ? $urandom_range(255) : header);
      write_reg(CSR_ARENA, headroom < 0 ? $urandom_range(32'h3FF_FFFF, 32'(arena_end))
                                        : arena_end + headroom);
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      repeat (130) send_random_word(65);
      wait_idle();
   endtask

   task automatic test_table_full;
      logic [AW-1:0] widest;
      write_reg(CSR_HEADER, 32'(ffba_pkg::HEADER_RESET));
      write_reg(CSR_ARENA, 32'h3FF_FFFF);
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      // Requests wider than every free block always append.
      widest = '0;
      for (int i = 0; i < blk_count; i++) begin
         if (blk_table[i].free && blk_table[i].size > widest) widest = blk_table[i].size;
      end
      for (int n = 0; n < MAX_BLOCKS && blk_count < MAX_BLOCKS; n++) begin
         send_word(ffba_pkg::MODE_ALLOC, widest + 1'b1, AW'($urandom));
      end
      send_word(ffba_pkg::MODE_ALLOC, widest + 1'b1, '0);
      send_word(ffba_pkg::MODE_ALLOC, '0, '0);
      send_word(ffba_pkg::MODE_FREE, '0, payload_of(blk_count - 1));
      send_word(ffba_pkg::MODE_ALLOC, widest + 1'b1, '0);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = ffba_pkg::MODE_ALLOC;
      req_ch.req_size = '0;
      req_ch.payload_addr = '0;
      rsp_ch.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_alloc_and_free();
      test_config_edges();
      test_backpressure();
      test_random_traffic(16, 3000, 0, 0);
      test_random_traffic(0, 1 << 23, 87, 0);
      test_random_traffic(255, 20000, 0, 87);
      test_table_full();
      test_random_traffic(-1, -1, 8, 8);

      // Catch any stray response after the last expected one.
      repeat (MAX_BLOCKS + 16) @(posedge clock);
      $display("Ran %0d allocate and %0d free words in %0d cycles, %0d blocks in the table.",
               n_allocs, n_frees, cycle_count, blk_count);
      $display("Outcomes: %0d ok, %0d bad size, %0d table full, %0d arena full, %0d bad free.",
               status_seen[ffba_pkg::STATUS_OK], status_seen[ffba_pkg::STATUS_BAD_SIZE],
               status_seen[ffba_pkg::STATUS_TABLE_FULL],
               status_seen[ffba_pkg::STATUS_ARENA_FULL],
               status_seen[ffba_pkg::STATUS_FREE_FAILED]);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: first_fit_block_allocator.f
src/ffba_pkg.sv
src/ffba_ifs.sv
src/ffba_csr.sv
src/ffba_table.sv
src/ffba_match.sv
src/ffba_engine.sv
src/first_fit_block_allocator.sv
tb/sv/tb.sv
